// ===== hw/rtl/lzss_window_decoder_assert.svh =====
// Assertion macros for the LZSS window decoder checker.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef LZSS_WINDOW_DECODER_ASSERT_SVH
`define LZSS_WINDOW_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LZWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lzwd_pkg.sv =====
// Shared types and constants for the LZSS window decoder.
// No dependencies; imported by every module of the block.
package lzwd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int COUNT_W          = 32;
    localparam int DIST_W           = 13;
    localparam int LEN_FIELD_W      = 4;
    localparam int LEN_W            = 5;
    localparam int LEN_BIAS         = 3;
    localparam int TOKENS_PER_FLAG  = 8;
    localparam int TOKEN_IDX_W      = $clog2(TOKENS_PER_FLAG);

    typedef struct packed {
        logic       stream_start;
        logic [7:0] compressed_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } out_item_t;

endpackage

// ===== hw/rtl/lzwd_history_ram.sv =====
// History window memory: one write port, one registered read port.
// A read of the entry written at the same edge returns the new byte.
module lzwd_history_ram #(
    parameter int DEPTH  = lzwd_pkg::WINDOW_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);
    import lzwd_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] ram_q_reg;
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        ram_q_reg    <= mem[rd_addr];
        fwd_reg      <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg <= wr_data;
    end

    // The array reads old data on a collision, so the written byte is bypassed.
    assign rd_data = fwd_reg ? fwd_data_reg : ram_q_reg;

endmodule

// ===== hw/rtl/lzss_window_decoder.sv =====
// Channel   Dir  Ports                     Payload
// s_        in   s_valid/s_ready/s_data    stream_start, compressed_byte
// m_        out  m_valid/m_ready/m_data    out_byte, run_end
// cfg_      in   cfg_wr_en/cfg_wr_data     output_limit (no handshake)
//
// A literal leaves one beat; flag, reference low and ignored bytes leave none.
// A reference high byte starts a copy of 3 to 18 bytes (fewer when the limit cuts it), one
// beat per cycle while m_ready is high, with one RAM read and one write per copied byte.
// s_ready rises once the last copy beat is loaded and the output slot is free.
// Reset is synchronous and active low; the history RAM is not cleared.
// A stall on m_ready freezes the copy, and s_ready stays low until the copy ends.
module lzss_window_decoder #(
    parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lzwd_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lzwd_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data
);
    import lzwd_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);

    // Parser phase: waiting for a flag byte, a token byte, or the reference high byte.
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_REF_HIGH
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_W-1:0]     produced_reg, produced_next;
    logic [7:0]             flag_bits_reg, flag_bits_next;
    logic [TOKEN_IDX_W-1:0] token_idx_reg, token_idx_next;
    logic [7:0]             ref_low_reg, ref_low_next;
    logic [COUNT_W-1:0]     limit_reg;

    // Copy engine state.
    logic                   copy_active_reg, copy_active_next;
    logic [ADDR_W-1:0]      copy_src_reg, copy_src_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic [LEN_W-1:0]       left_reg, left_next;

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    // Effective state once a stream start has been applied.
    phase_t                 phase_eff;
    logic [COUNT_W-1:0]     produced_eff;
    logic [TOKEN_IDX_W-1:0] token_idx_eff;

    logic                   accept;
    logic                   slot_free;
    logic                   emit;
    logic [7:0]             emit_byte;
    logic [ADDR_W-1:0]      wr_ptr;
    logic [7:0]             ram_rdata;
    logic [15:0]            ref_word;

    // The RAM address always follows the next copy source, so its data lines
    // up with copy_src_reg in the following cycle.
    lzwd_history_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (emit),
        .wr_addr (wr_ptr),
        .wr_data (emit_byte),
        .rd_addr (copy_src_next),
        .rd_data (ram_rdata)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = !copy_active_reg && slot_free;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign ref_word  = {s_data.compressed_byte, ref_low_reg};

    always_comb begin
        // A stream start clears the count and parser position, not the flag byte.
        if (s_data.stream_start) begin
            produced_eff  = '0;
            phase_eff     = PH_FLAG;
            token_idx_eff = '0;
        end else begin
            produced_eff  = produced_reg;
            phase_eff     = phase_reg;
            token_idx_eff = token_idx_reg;
        end

        phase_next       = phase_reg;
        produced_next    = produced_reg;
        flag_bits_next   = flag_bits_reg;
        token_idx_next   = token_idx_reg;
        ref_low_next     = ref_low_reg;
        copy_active_next = copy_active_reg;
        copy_src_next    = copy_src_reg;
        dist_next        = dist_reg;
        left_next        = left_reg;
        emit             = 1'b0;
        emit_byte        = s_data.compressed_byte;
        wr_ptr           = produced_reg[ADDR_W-1:0];
        m_data_next      = m_data_reg;

        if (accept) begin
            produced_next  = produced_eff;
            phase_next     = phase_eff;
            token_idx_next = token_idx_eff;
            // Once the limit is reached every byte is dropped until the next start.
            if (produced_eff < limit_reg) begin
                case (phase_eff)
                    PH_TOKEN: begin
                        if (flag_bits_reg[token_idx_eff]) begin
                            emit                 = 1'b1;
                            wr_ptr               = produced_eff[ADDR_W-1:0];
                            produced_next        = produced_eff + COUNT_W'(1);
                            m_data_next.out_byte = s_data.compressed_byte;
                            m_data_next.run_end  = 1'b1;
                            if (token_idx_eff == TOKEN_IDX_W'(TOKENS_PER_FLAG - 1)) begin
                                token_idx_next = '0;
                                phase_next     = PH_FLAG;
                            end else begin
                                token_idx_next = token_idx_eff + TOKEN_IDX_W'(1);
                                phase_next     = PH_TOKEN;
                            end
                        end else begin
                            ref_low_next = s_data.compressed_byte;
                            phase_next   = PH_REF_HIGH;
                        end
                    end
                    PH_REF_HIGH: begin
                        dist_next = {1'b0, ref_word[15:LEN_FIELD_W]} + DIST_W'(1);
                        left_next = {1'b0, ref_word[LEN_FIELD_W-1:0]} + LEN_W'(LEN_BIAS);
                        copy_src_next    = produced_eff[ADDR_W-1:0] - dist_next[ADDR_W-1:0];
                        copy_active_next = 1'b1;
                        if (token_idx_eff == TOKEN_IDX_W'(TOKENS_PER_FLAG - 1)) begin
                            token_idx_next = '0;
                            phase_next     = PH_FLAG;
                        end else begin
                            token_idx_next = token_idx_eff + TOKEN_IDX_W'(1);
                            phase_next     = PH_TOKEN;
                        end
                    end
                    default: begin
                        flag_bits_next = s_data.compressed_byte;
                        token_idx_next = '0;
                        phase_next     = PH_TOKEN;
                    end
                endcase
            end
        end else if (copy_active_reg && slot_free) begin
            // A distance reaching before the start of the stream yields zero.
            if ({{(COUNT_W - DIST_W){1'b0}}, dist_reg} > produced_reg) begin
                emit_byte = '0;
            end else begin
                emit_byte = ram_rdata;
            end
            emit                 = 1'b1;
            wr_ptr               = produced_reg[ADDR_W-1:0];
            produced_next        = produced_reg + COUNT_W'(1);
            copy_src_next        = copy_src_reg + ADDR_W'(1);
            left_next            = left_reg - LEN_W'(1);
            m_data_next.out_byte = emit_byte;
            m_data_next.run_end  = (left_reg == LEN_W'(1))
                                || (produced_next == limit_reg);
            if (m_data_next.run_end) begin
                copy_active_next = 1'b0;
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_FLAG;
            produced_reg    <= '0;
            flag_bits_reg   <= '0;
            token_idx_reg   <= '0;
            ref_low_reg     <= '0;
            limit_reg       <= '0;
            copy_active_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            produced_reg    <= produced_next;
            flag_bits_reg   <= flag_bits_next;
            token_idx_reg   <= token_idx_next;
            ref_low_reg     <= ref_low_next;
            copy_active_reg <= copy_active_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Copy datapath and output payload carry no reset.
    always_ff @(posedge aclk) begin
        copy_src_reg <= copy_src_next;
        dist_reg     <= dist_next;
        left_reg     <= left_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ===== hw/rtl/lzwd_checker.sv =====
// Port-level checker for the LZSS window decoder, bound to the top level.
// Depends on lzwd_pkg and the macros in lzss_window_decoder_assert.svh.
`include "lzss_window_decoder_assert.svh"

module lzwd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lzwd_pkg::out_item_t m_data
);
    import lzwd_pkg::*;

    // A stalled beat holds its payload.
    `LZWD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "output beat changed while stalled")

    // While a copy still has beats to go, no new input is taken.
    `LZWD_ASSERT_NOW(a_busy_in_copy, m_valid && !m_data.run_end, !s_ready, "input ready in the middle of a copy")

    // A taken copy beat that is not the last is followed at once by the next.
    `LZWD_ASSERT_NEXT(a_copy_gapless, m_valid && m_ready && !m_data.run_end, m_valid, "gap inside a copy")

    // Nothing is presented right after reset.
    `LZWD_ASSERT_NOW(a_reset_idle, $past(!aresetn), !m_valid, "output valid right after reset")

endmodule

bind lzss_window_decoder lzwd_checker u_lzwd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
